/* design/nmea_sentence_framer_top_assert.svh */
// Assertion macros for the NMEA sentence framer.
`ifndef NMEA_SENTENCE_FRAMER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NSF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define NSF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

/* design/nsf_pkg.sv */
// Package with constants and helpers for the NMEA sentence framer.
package nsf_pkg;

    localparam int DATA_W           = 8;
    localparam int POS_W            = 9;
    localparam int BUFFER_BYTES_DEF = 512;
    // Room kept free in the buffer for '*' and both checksum characters.
    localparam int HEADROOM         = 5;

    localparam logic [DATA_W-1:0] CH_DOLLAR      = 8'h24;
    localparam logic [DATA_W-1:0] CH_STAR        = 8'h2A;
    localparam logic [DATA_W-1:0] NIBBLE_MASK    = 8'h0F;
    localparam logic [DATA_W-1:0] HEX_DIGIT_BASE = 8'h30;
    // 'A' minus ten, so a nibble of ten or more maps straight onto 'A'..'F'.
    localparam logic [DATA_W-1:0] HEX_ALPHA_BASE = 8'h37;
    localparam logic [DATA_W-1:0] HEX_TEN        = 8'd10;

    // Uppercase hex character for the low nibble of a byte.
    function automatic logic [DATA_W-1:0] hex_upper(input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] nib;
        nib = value & NIBBLE_MASK;
        return (nib < HEX_TEN) ? (HEX_DIGIT_BASE + nib) : (HEX_ALPHA_BASE + nib);
    endfunction

endpackage

/* design/nmea_sentence_framer_top.sv */
// NMEA 0183 sentence framer with checksum check, one UART byte per transfer.
//
//  channel | direction | ports
//  --------+-----------+----------------------------------------------------------
//  s_      | in        | s_valid, s_ready, s_rx_byte
//  m_      | out       | m_valid, m_ready, m_data_byte, m_stored, m_position,
//          |           | m_overflow_drop, m_frame_end, m_frame_ok, m_frame_length
//
//  One byte per cycle unless stalled; a result shows the cycle after its transfer.
//  Frame state and the result register update in the same cycle as the transfer.
//  s_ready is low only while a result is held and m_ready is low.
//  Reset returns the framer to waiting for '$' with count, XOR and check char cleared.
module nmea_sentence_framer_top #(
    parameter int BUFFER_BYTES = nsf_pkg::BUFFER_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nsf_pkg::DATA_W-1:0] s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [nsf_pkg::DATA_W-1:0] m_data_byte,
    output logic                       m_stored,
    output logic [nsf_pkg::POS_W-1:0]  m_position,
    output logic                       m_overflow_drop,
    output logic                       m_frame_end,
    output logic                       m_frame_ok,
    output logic [nsf_pkg::POS_W-1:0]  m_frame_length
);
    import nsf_pkg::*;

`include "nmea_sentence_framer_top_assert.svh"

    localparam int CNT_W = $clog2(BUFFER_BYTES);
    localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_BYTES - HEADROOM);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_STAR,
        MODE_CS1
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DATA_W-1:0]  xor_reg, xor_next;
    logic [DATA_W-1:0]  check_reg, check_next;

    logic               stored_next, drop_next, fend_next, fok_next;
    logic [CNT_W-1:0]   pos_cnt, len_cnt;
    logic [EXT_W-1:0]   pos_ext, len_ext;
    logic               accept;
    logic [CNT_W-1:0]   body_cnt;

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    // '$' inside the body restarts the write position before the limit check
    assign body_cnt = (s_rx_byte == CH_DOLLAR) ? '0 : count_reg;

    // Frame sequencing for the byte on the input port
    always_comb begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        check_next  = check_reg;
        stored_next = 1'b0;
        drop_next   = 1'b0;
        fend_next   = 1'b0;
        fok_next    = 1'b0;
        pos_cnt     = '0;
        len_cnt     = '0;
        case (mode_reg)
            MODE_IDLE: begin
                if (s_rx_byte == CH_DOLLAR) begin
                    mode_next   = MODE_BODY;
                    xor_next    = '0;
                    stored_next = 1'b1;
                    count_next  = CNT_ONE;
                end
            end
            MODE_BODY: begin
                if (body_cnt >= LIMIT) begin
                    // sentence too long: drop it
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                    xor_next   = '0;
                    drop_next  = 1'b1;
                end else begin
                    if (s_rx_byte == CH_DOLLAR) begin
                        xor_next = '0;
                    end else if (s_rx_byte == CH_STAR) begin
                        mode_next = MODE_STAR;
                    end else begin
                        xor_next = xor_reg ^ s_rx_byte;
                    end
                    stored_next = 1'b1;
                    pos_cnt     = body_cnt;
                    count_next  = body_cnt + CNT_ONE;
                end
            end
            MODE_STAR: begin
                check_next  = s_rx_byte;
                stored_next = 1'b1;
                pos_cnt     = count_reg;
                count_next  = count_reg + CNT_ONE;
                mode_next   = MODE_CS1;
            end
            MODE_CS1: begin
                stored_next = 1'b1;
                pos_cnt     = count_reg;
                fend_next   = 1'b1;
                if (check_reg == hex_upper(xor_reg >> 4) &&
                    s_rx_byte == hex_upper(xor_reg)) begin
                    fok_next = 1'b1;
                    len_cnt  = count_reg + CNT_ONE;
                end
                mode_next  = MODE_IDLE;
                count_next = '0;
                xor_next   = '0;
            end
            default: begin
                mode_next  = MODE_IDLE;
                count_next = '0;
                xor_next   = '0;
            end
        endcase
    end

    // Map the counter onto the 9-bit position fields
    assign pos_ext = EXT_W'(pos_cnt);
    assign len_ext = EXT_W'(len_cnt);

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            xor_reg   <= '0;
            check_reg <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg        <= mode_next;
                count_reg       <= count_next;
                xor_reg         <= xor_next;
                check_reg       <= check_next;
                m_data_byte     <= s_rx_byte;
                m_stored        <= stored_next;
                m_position      <= pos_ext[POS_W-1:0];
                m_overflow_drop <= drop_next;
                m_frame_end     <= fend_next;
                m_frame_ok      <= fok_next;
                m_frame_length  <= len_ext[POS_W-1:0];
                m_valid         <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // Checks
    `NSF_ASSERT_NOW(a_ok_needs_end, aclk, aresetn, m_valid && m_frame_ok, m_frame_end)
    `NSF_ASSERT_NOW(a_drop_not_stored, aclk, aresetn, m_valid && m_overflow_drop, !m_stored)
    `NSF_ASSERT_NOW(a_ok_has_length, aclk, aresetn, m_valid && m_frame_ok, m_frame_length != '0)
    `NSF_ASSERT_NOW(a_idle_count_zero, aclk, aresetn, mode_reg == MODE_IDLE, count_reg == '0)
    `NSF_ASSERT_NEXT(a_end_to_idle, aclk, aresetn, accept && fend_next,
        mode_reg == MODE_IDLE && m_valid && m_frame_end)

endmodule
